[hdl/rvm_pkg.sv]
// ----------------------------------------------------------------------------
// rvm_pkg: shared definitions of the resampling voice mixer
// widths, stream packing and register index codes
// ----------------------------------------------------------------------------
package rvm_pkg;

    localparam int DEF_BUFFER_DEPTH  = 1024;
    localparam int DEF_FRACTION_BITS = 24;

    localparam int PER_FRAME_LIMIT = 64;
    localparam int RES_W           = $clog2(PER_FRAME_LIMIT);
    localparam int NARROW_BITS     = 8;
    localparam int WIDE_SHIFT      = 8;

    localparam int POS_W      = 10;
    localparam int CNT_W      = 11;
    localparam int SAMPLE_W   = 16;
    localparam int ACC_W      = 32;
    localparam int INDEX_W    = 16;
    localparam int VOL_W      = 8;
    localparam int START_W    = 24;
    localparam int STEP_W     = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam int S_TDATA_W = 48;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 80;
    localparam int M_TUSER_W = 1;

    localparam logic MODE_MIX   = 1'b0;
    localparam logic MODE_DRAIN = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEFT_VOLUME    = 3'd0,
        CFG_RIGHT_VOLUME   = 3'd1,
        CFG_SOURCE_STEREO  = 3'd2,
        CFG_SOURCE_WIDE    = 3'd3,
        CFG_RATE_STEP      = 3'd4,
        CFG_START_FRACTION = 3'd5,
        CFG_OUTPUT_OFFSET  = 3'd6,
        CFG_OUTPUT_COUNT   = 3'd7
    } t_cfg_index;

endpackage

[hdl/resampling_voice_mixer_core.sv]
// ----------------------------------------------------------------------------
// resampling_voice_mixer_core: nearest-sample resampling voice mixer
// mixes one voice into a stereo accumulator ram and drains clipped samples
// ----------------------------------------------------------------------------
// mix request: setup (accept, position), which may end with no result, then
//   per result a ram read, then add and write back with the result registered
// drain request: accept, ram read, then the clipped result is registered and
//   the slot zeroed; one request at a time; a stalled result holds the engine in place
// reset: a clearing pass zeroes the ram, no request is taken meanwhile;
//   configuration writes are taken whenever out of reset
module resampling_voice_mixer_core #(
    parameter int BUFFER_DEPTH  = rvm_pkg::DEF_BUFFER_DEPTH,
    parameter int FRACTION_BITS = rvm_pkg::DEF_FRACTION_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [rvm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [rvm_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // left_sample, right_sample, drain_position, zero pad
    input  logic [rvm_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // mode, first_frame
    input  logic [rvm_pkg::S_TUSER_W-1:0]    s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // position, left_value, right_value, zero pad
    output logic [rvm_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    // voice_done
    output logic [rvm_pkg::M_TUSER_W-1:0]    m_axis_tuser,
    output logic                             m_axis_tlast
);

    localparam int AW        = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int PH_W      = rvm_pkg::STEP_W + 1;
    localparam int MEM_W     = 2 * rvm_pkg::ACC_W;
    localparam int SUM_W     = rvm_pkg::POS_W + 2;
    localparam logic [rvm_pkg::STEP_W-1:0] MIN_STEP = rvm_pkg::STEP_W'(1) << (FRACTION_BITS - 6);
    localparam logic [rvm_pkg::STEP_W-1:0] ONE_STEP = rvm_pkg::STEP_W'(1) << FRACTION_BITS;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_START = 5'b00100,
        S_READ  = 5'b01000,
        S_MOD   = 5'b10000
    } t_state;

    function automatic logic [AW-1:0] wrap_pos(input logic [SUM_W-1:0] v);
        logic [31:0] t;
        t = 32'(v);
        for (int k = 5; k >= 0; k--) begin
            if (t >= (32'(BUFFER_DEPTH) << k)) begin
                t = t - (32'(BUFFER_DEPTH) << k);
            end
        end
        return t[AW-1:0];
    endfunction

    function automatic logic [rvm_pkg::ACC_W-1:0] scale(
        input logic [rvm_pkg::SAMPLE_W-1:0] raw,
        input logic [rvm_pkg::VOL_W-1:0]    vol,
        input logic                         wide
    );
        logic signed [rvm_pkg::SAMPLE_W-1:0] s;
        logic signed [24:0]                  p;
        s = wide ? signed'(raw)
                 : rvm_pkg::SAMPLE_W'(signed'(raw[rvm_pkg::NARROW_BITS-1:0]));
        p = s * signed'({1'b0, vol});
        return wide ? rvm_pkg::ACC_W'(p >>> rvm_pkg::WIDE_SHIFT) : rvm_pkg::ACC_W'(p);
    endfunction

    function automatic logic [rvm_pkg::ACC_W-1:0] clip16(input logic [rvm_pkg::ACC_W-1:0] v);
        if (signed'(v) > 32'sd32767) begin
            return 32'h0000_7FFF;
        end else if (signed'(v) < -32'sd32768) begin
            return 32'hFFFF_8000;
        end
        return v;
    endfunction

    t_state r_state;

    logic [rvm_pkg::VOL_W-1:0]    r_left_volume;
    logic [rvm_pkg::VOL_W-1:0]    r_right_volume;
    logic                         r_source_stereo;
    logic                         r_source_wide;
    logic [rvm_pkg::STEP_W-1:0]   r_rate_step;
    logic [rvm_pkg::START_W-1:0]  r_start_fraction;
    logic [rvm_pkg::POS_W-1:0]    r_output_offset;
    logic [rvm_pkg::CNT_W-1:0]    r_output_count;

    logic [rvm_pkg::INDEX_W-1:0]  r_frame_counter;
    logic [rvm_pkg::INDEX_W-1:0]  r_next_index;
    logic [FRACTION_BITS-1:0]     r_phase;
    logic [rvm_pkg::CNT_W-1:0]    r_filled;

    logic                         r_drain;
    logic [rvm_pkg::ACC_W-1:0]    r_add_l;
    logic [rvm_pkg::ACC_W-1:0]    r_add_r;
    logic [AW-1:0]                r_pos;
    logic [PH_W-1:0]              r_ph;
    logic [rvm_pkg::RES_W-1:0]    r_n;
    logic [AW-1:0]                r_clr_addr;

    logic                         r_out_valid;
    logic [rvm_pkg::POS_W-1:0]    r_out_pos;
    logic [rvm_pkg::ACC_W-1:0]    r_out_left;
    logic [rvm_pkg::ACC_W-1:0]    r_out_right;
    logic                         r_out_done;
    logic                         r_out_last;

    logic                         w_mode;
    logic                         w_first;
    logic [rvm_pkg::SAMPLE_W-1:0] w_left;
    logic [rvm_pkg::SAMPLE_W-1:0] w_right;
    logic [rvm_pkg::POS_W-1:0]    w_drain_pos;
    logic                         w_in_acc;
    logic [rvm_pkg::CNT_W-1:0]    w_limit;
    logic [rvm_pkg::STEP_W-1:0]   w_step;
    logic [rvm_pkg::INDEX_W-1:0]  w_next_index;
    logic [rvm_pkg::CNT_W-1:0]    w_filled_inc;
    logic                         w_more;
    logic                         w_out_free;
    logic                         w_go;
    logic [MEM_W-1:0]             w_rdata;
    logic [rvm_pkg::ACC_W-1:0]    w_sum_l;
    logic [rvm_pkg::ACC_W-1:0]    w_sum_r;
    logic                         w_we;
    logic [AW-1:0]                w_waddr;
    logic [MEM_W-1:0]             w_wdata;

    assign w_mode      = s_axis_tuser[0];
    assign w_first     = s_axis_tuser[1];
    assign w_left      = s_axis_tdata[15:0];
    assign w_right     = s_axis_tdata[31:16];
    assign w_drain_pos = s_axis_tdata[41:32];

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;

    assign w_limit = (32'(r_output_count) > 32'(BUFFER_DEPTH)) ?
                     rvm_pkg::CNT_W'(BUFFER_DEPTH) : r_output_count;
    assign w_step  = (r_rate_step < MIN_STEP) ? MIN_STEP : r_rate_step;

    assign w_next_index = r_next_index + rvm_pkg::INDEX_W'(r_ph >> FRACTION_BITS);
    assign w_filled_inc = r_filled + rvm_pkg::CNT_W'(1);
    assign w_more       = (r_n != rvm_pkg::RES_W'(rvm_pkg::PER_FRAME_LIMIT - 1)) &&
                          (w_filled_inc < w_limit) &&
                          (w_next_index == r_frame_counter);

    assign w_out_free = !r_out_valid || m_axis_tready;
    assign w_go       = (r_state == S_MOD) && w_out_free;

    assign w_sum_l = w_rdata[rvm_pkg::ACC_W-1:0] + r_add_l;
    assign w_sum_r = w_rdata[MEM_W-1:rvm_pkg::ACC_W] + r_add_r;

    // drain and clear write zeros, mix writes the updated pair
    assign w_we    = (r_state == S_CLEAR) || w_go;
    assign w_waddr = (r_state == S_CLEAR) ? r_clr_addr : r_pos;
    assign w_wdata = ((r_state == S_CLEAR) || r_drain) ? '0 : {w_sum_r, w_sum_l};

    rvm_ram #(
        .WIDTH (MEM_W),
        .DEPTH (BUFFER_DEPTH)
    ) u_acc_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_pos),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_CLEAR;
            r_clr_addr       <= '0;
            r_left_volume    <= '0;
            r_right_volume   <= '0;
            r_source_stereo  <= 1'b0;
            r_source_wide    <= 1'b1;
            r_rate_step      <= ONE_STEP;
            r_start_fraction <= '0;
            r_output_offset  <= '0;
            r_output_count   <= '0;
            r_frame_counter  <= '0;
            r_next_index     <= '0;
            r_phase          <= '0;
            r_filled         <= '0;
            r_n              <= '0;
            r_drain          <= 1'b0;
            r_out_valid      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (rvm_pkg::t_cfg_index'(i_cfg_index))
                    rvm_pkg::CFG_LEFT_VOLUME:    r_left_volume    <= i_cfg_data[7:0];
                    rvm_pkg::CFG_RIGHT_VOLUME:   r_right_volume   <= i_cfg_data[7:0];
                    rvm_pkg::CFG_SOURCE_STEREO:  r_source_stereo  <= i_cfg_data[0];
                    rvm_pkg::CFG_SOURCE_WIDE:    r_source_wide    <= i_cfg_data[0];
                    rvm_pkg::CFG_RATE_STEP:      r_rate_step      <= i_cfg_data;
                    rvm_pkg::CFG_START_FRACTION: r_start_fraction <= i_cfg_data[23:0];
                    rvm_pkg::CFG_OUTPUT_OFFSET:  r_output_offset  <= i_cfg_data[9:0];
                    rvm_pkg::CFG_OUTPUT_COUNT:   r_output_count   <= i_cfg_data[10:0];
                endcase
            end

            if (w_go) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tvalid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                    if (r_clr_addr == AW'(BUFFER_DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_add_l <= scale(w_left, r_left_volume, r_source_wide);
                        r_add_r <= scale(r_source_stereo ? w_right : w_left,
                                         r_right_volume, r_source_wide);
                        r_drain <= (w_mode == rvm_pkg::MODE_DRAIN);
                        r_n     <= '0;
                        if (w_mode == rvm_pkg::MODE_DRAIN) begin
                            r_pos   <= wrap_pos(SUM_W'(w_drain_pos));
                            r_state <= S_READ;
                        end else begin
                            if (w_first) begin
                                r_frame_counter <= '0;
                                r_next_index    <= '0;
                                r_filled        <= '0;
                                r_phase         <= FRACTION_BITS'(r_start_fraction);
                            end
                            r_state <= S_START;
                        end
                    end
                end
                S_START: begin
                    r_pos <= wrap_pos(SUM_W'(r_output_offset) + SUM_W'(r_filled));
                    if ((r_filled < w_limit) && (r_next_index == r_frame_counter)) begin
                        r_state <= S_READ;
                    end else begin
                        r_frame_counter <= r_frame_counter + rvm_pkg::INDEX_W'(1);
                        r_state         <= S_IDLE;
                    end
                end
                S_READ: begin
                    r_ph    <= PH_W'(r_phase) + PH_W'(w_step);
                    r_state <= S_MOD;
                end
                S_MOD: begin
                    if (w_out_free) begin
                        r_out_pos   <= rvm_pkg::POS_W'(r_pos);
                        if (r_drain) begin
                            r_out_left  <= clip16(w_rdata[rvm_pkg::ACC_W-1:0]);
                            r_out_right <= clip16(w_rdata[MEM_W-1:rvm_pkg::ACC_W]);
                            r_out_done  <= (r_filled >= w_limit);
                            r_out_last  <= 1'b1;
                            r_state     <= S_IDLE;
                        end else begin
                            r_out_left   <= w_sum_l;
                            r_out_right  <= w_sum_r;
                            r_out_done   <= (w_filled_inc >= w_limit);
                            r_out_last   <= !w_more;
                            r_filled     <= w_filled_inc;
                            r_phase      <= r_ph[FRACTION_BITS-1:0];
                            r_next_index <= w_next_index;
                            r_n          <= r_n + rvm_pkg::RES_W'(1);
                            r_pos        <= (r_pos == AW'(BUFFER_DEPTH - 1)) ?
                                            '0 : r_pos + AW'(1);
                            if (w_more) begin
                                r_state <= S_READ;
                            end else begin
                                r_frame_counter <= r_frame_counter + rvm_pkg::INDEX_W'(1);
                                r_state         <= S_IDLE;
                            end
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = rvm_pkg::M_TDATA_W'({r_out_right, r_out_left, r_out_pos});
    assign m_axis_tuser  = r_out_done;
    assign m_axis_tlast  = r_out_last;

endmodule

[hdl/rvm_ram.sv]
// ----------------------------------------------------------------------------
// rvm_ram: generic single-port-write, single-port-read ram
// one write and one registered read per cycle
// ----------------------------------------------------------------------------
module rvm_ram #(
    parameter int WIDTH = 2 * rvm_pkg::ACC_W,
    parameter int DEPTH = rvm_pkg::DEF_BUFFER_DEPTH,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/rvm_checker.sv]
// ----------------------------------------------------------------------------
// rvm_checker: port-level checks of the resampling voice mixer
// bound to the top level
// ----------------------------------------------------------------------------
module rvm_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [rvm_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input logic [rvm_pkg::M_TUSER_W-1:0] m_axis_tuser,
    input logic                          m_axis_tlast
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
             $stable(m_axis_tlast)))
        else $error("stalled result changed");

    // reset empties the output register
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // clearing pass follows reset
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_axis_tready)
        else $error("request taken during clearing pass");

    // one request in work at a time
    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request taken while one is in work");

endmodule

bind resampling_voice_mixer_core rvm_checker u_rvm_checker (.*);
